// ===== hdl/hlcv_pkg.sv =====
// hlcv_pkg: shared constants, codes and types for the lane colour vote block.
// No dependencies; every other file in hdl/ imports this package.
package hlcv_pkg;

    localparam int PIX_BITS   = 8;
    localparam int COUNT_BITS = 20;   // tally width, 8..32
    localparam int OUT_BITS   = 20;   // reported vote width
    localparam int WIDE_BITS  = 33;   // holds any tally or report for compares

    // shared divider: 17-bit numerator, 9-bit divisor, 8-bit quotient
    localparam int NUM_BITS  = 17;
    localparam int DEN_BITS  = 9;
    localparam int QUO_BITS  = 8;
    localparam int DIV_STEPS = QUO_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);
    localparam int DSH_BITS  = DEN_BITS + QUO_BITS - 1;

    // colour codes
    localparam logic [1:0] COL_WHITE  = 2'd0;
    localparam logic [1:0] COL_RED    = 2'd1;
    localparam logic [1:0] COL_YELLOW = 2'd2;

    // hue numerator arithmetic
    localparam int HUE_BITS = 19;
    localparam logic signed [HUE_BITS-1:0] HUE_SCALE  = 19'sd60;
    localparam logic signed [HUE_BITS-1:0] HUE_BASE_G = 19'sd120;
    localparam logic signed [HUE_BITS-1:0] HUE_BASE_B = 19'sd240;
    localparam logic signed [HUE_BITS-1:0] HUE_WRAP   = 19'sd360;

    // day boxes
    localparam logic [7:0] DW_S_MAX = 8'd60;
    localparam logic [7:0] DW_V_MIN = 8'd180;
    localparam logic [7:0] DR_H_MIN = 8'd120;
    localparam logic [7:0] DR_H_MAX = 8'd165;
    localparam logic [7:0] DR_S_MIN = 8'd43;
    localparam logic [7:0] DR_V_MIN = 8'd46;
    localparam logic [7:0] DY_H_MIN = 8'd90;
    localparam logic [7:0] DY_H_MAX = 8'd180;
    localparam logic [7:0] DY_S_MIN = 8'd60;
    localparam logic [7:0] DY_S_MAX = 8'd245;
    localparam logic [7:0] DY_V_MIN = 8'd160;

    // night boxes
    localparam logic [7:0] NW_H_MAX = 8'd170;
    localparam logic [7:0] NW_S_MAX = 8'd40;
    localparam logic [7:0] NW_V_MIN = 8'd60;
    localparam logic [7:0] NY_H_MIN = 8'd77;
    localparam logic [7:0] NY_H_MAX = 8'd117;
    localparam logic [7:0] NY_S_MIN = 8'd16;
    localparam logic [7:0] NY_S_MAX = 8'd116;
    localparam logic [7:0] NY_V_MIN = 8'd105;
    localparam logic [7:0] NY_V_MAX = 8'd252;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quot;
    } div_rsp_t;

endpackage

// ===== hdl/hlcv_pix_if.sv =====
// hlcv_pix_if: valid/ready channel carrying one RGB pixel item.
// Depends on hlcv_pkg.
interface hlcv_pix_if import hlcv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                last;

    modport source (output valid, red, green, blue, last, input ready);
    modport sink   (input valid, red, green, blue, last, output ready);
endinterface

// ===== hdl/hlcv_vote_if.sv =====
// hlcv_vote_if: valid/ready channel carrying one colour vote result item.
// Depends on hlcv_pkg.
interface hlcv_vote_if import hlcv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          colour;
    logic [OUT_BITS-1:0] white_votes;
    logic [OUT_BITS-1:0] red_votes;
    logic [OUT_BITS-1:0] yellow_votes;

    modport source (output valid, colour, white_votes, red_votes, yellow_votes, input ready);
    modport sink   (input valid, colour, white_votes, red_votes, yellow_votes, output ready);
endinterface

// ===== hdl/hlcv_div.sv =====
// hlcv_div: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on hlcv_pkg (div_req_t, div_rsp_t, widths).
module hlcv_div import hlcv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 run_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [NUM_BITS-1:0]  rem_reg;
    logic [DSH_BITS-1:0]  dsh_reg;
    logic [QUO_BITS-1:0]  quot_reg;

    logic                ge;
    logic [NUM_BITS-1:0] rem_next;

    // caller guarantees quotient < 2^QUO_BITS
    assign ge       = rem_reg >= NUM_BITS'(dsh_reg);
    assign rem_next = ge ? (rem_reg - NUM_BITS'(dsh_reg)) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= STEP_BITS'(DIV_STEPS - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= {req.den, (QUO_BITS-1)'(0)};
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUO_BITS-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== hdl/hsv_lane_colour_vote.sv =====
// hsv_lane_colour_vote: colour vote over the masked RGB pixels of one object.
// Depends on hlcv_pkg, hlcv_pix_if, hlcv_vote_if and hlcv_div.
//
//   port      dir   handshake        item
//   pix       in    valid/ready      red, green, blue (8b each), last
//   vote      out   valid/ready      colour (2b), white/red/yellow_votes (20b)
//   cfg_we    in    write enable     cfg_wdata -> night_mode (1b)
//
// Path: a pixel with red == 0 goes from accept straight to vote, a grey pixel
// passes prepare first, and a colored pixel adds two 8-step divisions (saturation,
// then hue) run back to back on the one shared divider between prepare and vote.
// One pixel is in flight at a time; pix.ready is high only when idle.
// Reset clears the tallies, night_mode and the output valid.
// A result waiting on vote.ready does not block new pixels; only a second
// last pixel waits in the vote cycle until the output register is free.
module hsv_lane_colour_vote import hlcv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hlcv_pix_if.sink     pix,
    hlcv_vote_if.source  vote,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIV_S = 3'd2;
    localparam logic [2:0] ST_DIV_H = 3'd3;
    localparam logic [2:0] ST_VOTE  = 3'd4;

    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

    function automatic logic [OUT_BITS-1:0] report(input logic [COUNT_BITS-1:0] t);
        logic [WIDE_BITS-1:0] ext;
        ext = WIDE_BITS'(t);
        return (ext > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : ext[OUT_BITS-1:0];
    endfunction

    logic [2:0]  state_reg, state_next;
    logic        night_reg;

    // pixel and derived values
    logic [PIX_BITS-1:0] r_reg, g_reg, b_reg;
    logic                last_reg;
    logic                en_reg;          // pixel takes part in the vote
    logic [PIX_BITS-1:0] v_reg, d_reg;
    logic [NUM_BITS-1:0] h6_reg;
    logic [QUO_BITS-1:0] s_reg, h_reg;

    logic [COUNT_BITS-1:0] w_tally_reg, r_tally_reg, y_tally_reg;
    logic [COUNT_BITS-1:0] w_tally_next, r_tally_next, y_tally_next;

    logic                vote_valid_reg;
    logic [1:0]          colour_reg;
    logic [OUT_BITS-1:0] w_out_reg, r_out_reg, y_out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    hlcv_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---- prepare: max/min, delta and the hue numerator --------------------
    logic [PIX_BITS-1:0]        mx, mn, dlt;
    logic signed [HUE_BITS-1:0] xs, ys, dls, base, h6_raw, h6_wrap;

    always_comb
    begin
        mx = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        mn = r_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        dlt = mx - mn;
        dls = signed'(HUE_BITS'(dlt));
        if (mx == r_reg)
        begin
            xs   = signed'(HUE_BITS'(g_reg));
            ys   = signed'(HUE_BITS'(b_reg));
            base = '0;
        end
        else if (mx == g_reg)
        begin
            xs   = signed'(HUE_BITS'(b_reg));
            ys   = signed'(HUE_BITS'(r_reg));
            base = HUE_BASE_G;
        end
        else
        begin
            xs   = signed'(HUE_BITS'(r_reg));
            ys   = signed'(HUE_BITS'(g_reg));
            base = HUE_BASE_B;
        end
        h6_raw  = (xs - ys) * HUE_SCALE + base * dls;
        h6_wrap = (h6_raw < 0) ? (h6_raw + HUE_WRAP * dls) : h6_raw;
    end

    // ---- divider requests --------------------------------------------------
    always_comb
    begin
        div_req = '0;
        if (state_reg == ST_PREP && dlt != '0)
        begin
            div_req.start = 1'b1;
            // 255 * d
            div_req.num   = NUM_BITS'({dlt, 8'd0}) - NUM_BITS'(dlt);
            div_req.den   = DEN_BITS'(mx);
        end
        else if (state_reg == ST_DIV_S && div_rsp.done)
        begin
            div_req.start = 1'b1;
            div_req.num   = h6_reg;
            div_req.den   = {d_reg, 1'b0};
        end
    end

    // ---- threshold boxes and tally update ---------------------------------
    logic hit_w, hit_r, hit_y;
    logic out_busy, out_load;

    always_comb
    begin
        if (!night_reg)
        begin
            hit_w = (s_reg <= DW_S_MAX) && (v_reg >= DW_V_MIN);
            hit_r = (h_reg >= DR_H_MIN) && (h_reg <= DR_H_MAX) &&
                    (s_reg >= DR_S_MIN) && (v_reg >= DR_V_MIN);
            hit_y = (h_reg >= DY_H_MIN) && (h_reg <= DY_H_MAX) &&
                    (s_reg >= DY_S_MIN) && (s_reg <= DY_S_MAX) && (v_reg >= DY_V_MIN);
        end
        else
        begin
            hit_w = (h_reg <= NW_H_MAX) && (s_reg <= NW_S_MAX) && (v_reg >= NW_V_MIN);
            hit_r = 1'b0;
            hit_y = (h_reg >= NY_H_MIN) && (h_reg <= NY_H_MAX) &&
                    (s_reg >= NY_S_MIN) && (s_reg <= NY_S_MAX) &&
                    (v_reg >= NY_V_MIN) && (v_reg <= NY_V_MAX);
        end
        hit_w = hit_w && en_reg;
        hit_r = hit_r && en_reg;
        hit_y = hit_y && en_reg;

        // saturating bumps
        w_tally_next = (hit_w && w_tally_reg != TALLY_MAX) ? w_tally_reg + 1'b1 : w_tally_reg;
        r_tally_next = (hit_r && r_tally_reg != TALLY_MAX) ? r_tally_reg + 1'b1 : r_tally_reg;
        y_tally_next = (hit_y && y_tally_reg != TALLY_MAX) ? y_tally_reg + 1'b1 : y_tally_reg;
    end

    assign out_busy = vote_valid_reg && !vote.ready;
    assign out_load = (state_reg == ST_VOTE) && last_reg && !out_busy;

    // ---- sequencer ---------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix.valid)
                    state_next = (pix.red != '0) ? ST_PREP : ST_VOTE;
            end
            ST_PREP:
            begin
                state_next = (dlt != '0) ? ST_DIV_S : ST_VOTE;
            end
            ST_DIV_S:
            begin
                if (div_rsp.done)
                    state_next = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                if (div_rsp.done)
                    state_next = ST_VOTE;
            end
            ST_VOTE:
            begin
                if (!(last_reg && out_busy))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pix.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            night_reg      <= 1'b0;
            vote_valid_reg <= 1'b0;
            w_tally_reg    <= '0;
            r_tally_reg    <= '0;
            y_tally_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                night_reg <= cfg_wdata;

            if (out_load)
                vote_valid_reg <= 1'b1;
            else if (vote.ready)
                vote_valid_reg <= 1'b0;

            if (state_reg == ST_VOTE && !(last_reg && out_busy))
            begin
                // a closed object starts over from zero
                w_tally_reg <= last_reg ? '0 : w_tally_next;
                r_tally_reg <= last_reg ? '0 : r_tally_next;
                y_tally_reg <= last_reg ? '0 : y_tally_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pix.valid)
        begin
            r_reg    <= pix.red;
            g_reg    <= pix.green;
            b_reg    <= pix.blue;
            last_reg <= pix.last;
            en_reg   <= (pix.red != '0);
        end
        if (state_reg == ST_PREP)
        begin
            v_reg  <= mx;
            d_reg  <= dlt;
            h6_reg <= NUM_BITS'(h6_wrap);
            // grey pixel: hue and saturation are zero
            s_reg  <= '0;
            h_reg  <= '0;
        end
        if (state_reg == ST_DIV_S && div_rsp.done)
            s_reg <= div_rsp.quot;
        if (state_reg == ST_DIV_H && div_rsp.done)
            h_reg <= div_rsp.quot;

        if (out_load)
        begin
            // ties go to white, then red
            if (w_tally_next >= r_tally_next && w_tally_next >= y_tally_next)
                colour_reg <= COL_WHITE;
            else if (r_tally_next >= y_tally_next)
                colour_reg <= COL_RED;
            else
                colour_reg <= COL_YELLOW;
            w_out_reg <= report(w_tally_next);
            r_out_reg <= report(r_tally_next);
            y_out_reg <= report(y_tally_next);
        end
    end

    assign vote.valid        = vote_valid_reg;
    assign vote.colour       = colour_reg;
    assign vote.white_votes  = w_out_reg;
    assign vote.red_votes    = r_out_reg;
    assign vote.yellow_votes = y_out_reg;

endmodule

// ===== hdl/hlcv_checker.sv =====
// hlcv_checker: port-level assertions for hsv_lane_colour_vote, with its bind.
// Depends on hlcv_pkg and the top level's ports.
module hlcv_checker import hlcv_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pix_valid,
    input logic                pix_ready,
    input logic                vote_valid,
    input logic                vote_ready,
    input logic [1:0]          colour,
    input logic [OUT_BITS-1:0] white_votes,
    input logic [OUT_BITS-1:0] red_votes,
    input logic [OUT_BITS-1:0] yellow_votes
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && !vote_ready |=> vote_valid && $stable(colour) &&
        $stable(white_votes) && $stable(red_votes) && $stable(yellow_votes))
        else $error("vote item changed while stalled");

    // one pixel at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel accepted while previous one in flight");

    a_white_max: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && colour == COL_WHITE |->
        white_votes >= red_votes && white_votes >= yellow_votes)
        else $error("white reported without majority");

    a_red_max: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && colour == COL_RED |->
        red_votes >= white_votes && red_votes >= yellow_votes)
        else $error("red reported without majority");

    a_yellow_max: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && colour == COL_YELLOW |->
        yellow_votes >= white_votes && yellow_votes >= red_votes)
        else $error("yellow reported without majority");

endmodule

bind hsv_lane_colour_vote hlcv_checker u_hlcv_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix.valid),
    .pix_ready    (pix.ready),
    .vote_valid   (vote.valid),
    .vote_ready   (vote.ready),
    .colour       (vote.colour),
    .white_votes  (vote.white_votes),
    .red_votes    (vote.red_votes),
    .yellow_votes (vote.yellow_votes)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for hsv_lane_colour_vote: directed and random pixel objects, checked by a
// built-in HSV vote predictor. Depends on hlcv_pkg, hlcv_pix_if, hlcv_vote_if and the RTL.
module testbench import hlcv_pkg::*; ();

    typedef struct {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
        logic                last;
    } pixel_t;

    typedef struct {
        logic [1:0]          colour;
        logic [OUT_BITS-1:0] white;
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] yellow;
    } vote_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hlcv_pix_if  pix_ch ();
    hlcv_vote_if vote_ch ();

    hsv_lane_colour_vote i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .vote      (vote_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state: mirrors the tallies and the night_mode register
    logic [COUNT_BITS-1:0] white_tally;
    logic [COUNT_BITS-1:0] red_tally;
    logic [COUNT_BITS-1:0] yellow_tally;
    logic                  night;

    vote_t pending_votes[$];   // votes owed by the block, oldest first
    int    failures;
    bit    calm;               // 1: no gaps on either side

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [COUNT_BITS-1:0] bumped(input logic [COUNT_BITS-1:0] t);
        // tallies saturate at all ones
        return (&t) ? t : t + 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] clipped(input logic [COUNT_BITS-1:0] t);
        // a tally wider than the report pins at the report maximum
        if (COUNT_BITS > OUT_BITS && t > {OUT_BITS{1'b1}})
            return {OUT_BITS{1'b1}};
        return OUT_BITS'(t);
    endfunction

    // Applies one accepted pixel; a last pixel owes one vote.
    function automatic void predict_pixel(input pixel_t px);
        int unsigned           mx;
        int unsigned           mn;
        int unsigned           d;
        int unsigned           hue;
        int unsigned           sat;
        int unsigned           val;
        int                    h6;
        logic [COUNT_BITS-1:0] best;
        vote_t                 res;

        if (px.red != 0)
        begin
            mx = px.red;
            mn = px.red;
            if (px.green > mx) mx = px.green;
            if (px.blue > mx)  mx = px.blue;
            if (px.green < mn) mn = px.green;
            if (px.blue < mn)  mn = px.blue;
            d   = mx - mn;
            val = mx;
            hue = 0;
            sat = 0;
            // grey pixel: hue and saturation stay 0
            if (d != 0)
            begin
                sat = (255 * d) / mx;
                if (mx == px.red)
                    h6 = 60 * (int'(px.green) - int'(px.blue));
                else if (mx == px.green)
                    h6 = 60 * (int'(px.blue) - int'(px.red)) + 120 * int'(d);
                else
                    h6 = 60 * (int'(px.red) - int'(px.green)) + 240 * int'(d);
                if (h6 < 0)
                    h6 += 360 * int'(d);
                hue = h6 / (2 * d);
            end
            // every matching box votes
            if (!night)
            begin
                if (sat <= 60 && val >= 180)
                    white_tally = bumped(white_tally);
                if (hue >= 120 && hue <= 165 && sat >= 43 && val >= 46)
                    red_tally = bumped(red_tally);
                if (hue >= 90 && hue <= 180 && sat >= 60 && sat <= 245 && val >= 160)
                    yellow_tally = bumped(yellow_tally);
            end
            else
            begin
                if (hue <= 170 && sat <= 40 && val >= 60)
                    white_tally = bumped(white_tally);
                if (hue >= 77 && hue <= 117 && sat >= 16 && sat <= 116 &&
                    val >= 105 && val <= 252)
                    yellow_tally = bumped(yellow_tally);
            end
        end

        // masked pixels still close the object
        if (px.last)
        begin
            best = white_tally;
            if (red_tally > best)    best = red_tally;
            if (yellow_tally > best) best = yellow_tally;
            // ties: white, then red, then yellow
            if (white_tally == best)
                res.colour = COL_WHITE;
            else if (red_tally == best)
                res.colour = COL_RED;
            else
                res.colour = COL_YELLOW;
            res.white  = clipped(white_tally);
            res.red    = clipped(red_tally);
            res.yellow = clipped(yellow_tally);
            pending_votes = {pending_votes, res};
            white_tally  = '0;
            red_tally    = '0;
            yellow_tally = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Pixel sender
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic pixel_t mk(input int r, input int g, input int b, input bit last);
        pixel_t px;
        px.red   = PIX_BITS'(r);
        px.green = PIX_BITS'(g);
        px.blue  = PIX_BITS'(b);
        px.last  = last;
        return px;
    endfunction

    // valid drops only for a gap, so a back-to-back item keeps it high
    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_ch.valid = 1'b1;
        pix_ch.red   = px.red;
        pix_ch.green = px.green;
        pix_ch.blue  = px.blue;
        pix_ch.last  = px.last;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        predict_pixel(px);
    endtask

    // Stops sending until every vote is back, then lets any non-last pixel finish.
    task automatic settle_block();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (pending_votes.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_night(input logic mode);
        settle_block();
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_we    = 1'b0;
        night     = mode;
    endtask

    // Mix of masked, grey, pale/tinted and raw colored pixels.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned r;
        int unsigned c;
        int unsigned spread;
        r = $urandom_range(0, 99);
        px.last = 1'b0;
        if (r < 12)
        begin
            px.red   = '0;
            px.green = PIX_BITS'($urandom_range(0, 255));
            px.blue  = PIX_BITS'($urandom_range(0, 255));
        end
        else if (r < 22)
        begin
            c = $urandom_range(1, 255);
            px.red   = PIX_BITS'(c);
            px.green = PIX_BITS'(c);
            px.blue  = PIX_BITS'(c);
        end
        else if (r < 50)
        begin
            // near-grey or lightly tinted, to reach the white and night boxes
            c = $urandom_range(40, 255);
            spread = $urandom_range(0, 1) ? c / 5 : c / 2;
            px.red   = PIX_BITS'(c - $urandom_range(0, spread));
            px.green = PIX_BITS'(c - $urandom_range(0, spread));
            px.blue  = PIX_BITS'(c - $urandom_range(0, spread));
        end
        else if (r < 75)
        begin
            px.red   = PIX_BITS'($urandom_range(1, 255));
            px.green = PIX_BITS'($urandom_range(0, 255));
            px.blue  = PIX_BITS'($urandom_range(0, 255));
        end
        else
        begin
            px.red   = PIX_BITS'($urandom_range(0, 255));
            px.green = PIX_BITS'($urandom_range(0, 255));
            px.blue  = PIX_BITS'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty objects and masked pixels: no votes, last still closes.
    task automatic test_empty_and_masked();
        send_pixel(mk(0, 0, 0, 1));
        send_pixel(mk(0, 255, 255, 0));
        send_pixel(mk(0, 128, 1, 1));
    endtask

    // Day boxes: white, red, yellow, overlaps, ties, hue wrap, channel extremes.
    task automatic test_day_boxes();
        send_pixel(mk(255, 255, 255, 1));    // white
        send_pixel(mk(1, 1, 1, 0));          // dark grey, no vote
        send_pixel(mk(200, 0, 255, 0));      // red
        send_pixel(mk(100, 50, 200, 1));     // red and yellow at once
        send_pixel(mk(50, 100, 200, 1));     // yellow only
        send_pixel(mk(200, 0, 255, 0));      // red ...
        send_pixel(mk(255, 255, 255, 1));    // ... ties white: white wins
        send_pixel(mk(255, 0, 10, 0));       // negative hue numerator wraps
        send_pixel(mk(10, 255, 0, 0));       // green is the max
        send_pixel(mk(255, 255, 0, 0));
        send_pixel(mk(255, 0, 0, 0));
        send_pixel(mk(1, 0, 0, 1));
    endtask

    task automatic test_night_boxes();
        send_pixel(mk(255, 255, 255, 0));    // night white
        send_pixel(mk(100, 100, 100, 0));    // night white
        send_pixel(mk(150, 170, 200, 1));    // night yellow
        send_pixel(mk(200, 0, 255, 1));      // day red box, nothing at night
        send_pixel(mk(40, 40, 40, 1));       // too dark: empty object
        send_pixel(mk(255, 255, 254, 1));
    endtask

    // Random objects; most short, some long to build up deep tallies.
    task automatic test_random_objects(input int count, input bit quiet);
        int          sent;
        int          len;
        int unsigned r;
        pixel_t      px;
        calm = quiet;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 120);
            for (int i = 0; i < len; i++)
            begin
                px = random_pixel();
                px.last = (i == len - 1);
                send_pixel(px);
            end
            sent += len;
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Vote sink: random stalls, a few of them long
    // ------------------------------------------------------------------

    initial
    begin : drive_vote_ready
        int          stall;
        int unsigned r;
        stall = 0;
        vote_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                vote_ch.ready = 1'b1;
            else if (stall > 0)
            begin
                vote_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    vote_ch.ready = 1'b1;
                else
                begin
                    vote_ch.ready = 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Vote checker: every accepted vote against the oldest one owed
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_votes
        vote_t want;
        if (rst_n && vote_ch.valid && vote_ch.ready)
        begin
            if (pending_votes.size() == 0)
            begin
                $error("vote: unexpected item, colour %0d", vote_ch.colour);
                failures++;
            end
            else
            begin
                want = pending_votes.pop_front();
                if (vote_ch.colour !== want.colour)
                begin
                    $error("colour: expected %0d, actual %0d", want.colour, vote_ch.colour);
                    failures++;
                end
                if (vote_ch.white_votes !== want.white)
                begin
                    $error("white_votes: expected %0d, actual %0d",
                           want.white, vote_ch.white_votes);
                    failures++;
                end
                if (vote_ch.red_votes !== want.red)
                begin
                    $error("red_votes: expected %0d, actual %0d",
                           want.red, vote_ch.red_votes);
                    failures++;
                end
                if (vote_ch.yellow_votes !== want.yellow)
                begin
                    $error("yellow_votes: expected %0d, actual %0d",
                           want.yellow, vote_ch.yellow_votes);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        failures     = 0;
        calm         = 1'b0;
        night        = 1'b0;
        white_tally  = '0;
        red_tally    = '0;
        yellow_tally = '0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        pix_ch.last  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        write_night(1'b0);
        test_empty_and_masked();
        test_day_boxes();
        write_night(1'b1);
        test_night_boxes();

        // random phases across both modes, with quiet stretches
        test_random_objects(300, 1'b0);
        write_night(1'b0);
        test_random_objects(500, 1'b0);
        test_random_objects(200, 1'b1);
        write_night(1'b1);
        test_random_objects(500, 1'b0);
        write_night(1'b0);
        test_random_objects(300, 1'b0);

        settle_block();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: well above the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== hsv_lane_colour_vote.f =====
hdl/hlcv_pkg.sv
hdl/hlcv_pix_if.sv
hdl/hlcv_vote_if.sv
hdl/hlcv_div.sv
hdl/hsv_lane_colour_vote.sv
hdl/hlcv_checker.sv
sim/testbench.sv
